// ===== sv/bbalc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared constants, operation codes and control structs for the bitmap block allocator.
// Used by the interfaces, the controller, the datapath and the top level.
package bbalc_pkg;

   localparam int NUM_BLOCKS_DEFAULT  = 4096;
   localparam int BLOCK_BYTES_DEFAULT = 4096;
   localparam int WORD_BITS           = 8;
   localparam int ADDR_BITS           = 48;
   localparam int COUNT_BITS          = 13;
   localparam int LEN_BITS            = 32;

   localparam logic [1:0] OP_ALLOC     = 2'd0;
   localparam logic [1:0] OP_FREE      = 2'd1;
   localparam logic [1:0] OP_MARK_USED = 2'd2;
   localparam logic [1:0] OP_MARK_FREE = 2'd3;

   localparam logic REG_REGION_BASE    = 1'b0;
   localparam logic REG_MANAGED_BLOCKS = 1'b1;

   typedef struct packed {
      logic load;
      logic calc_off;
      logic calc_first;
      logic calc_end;
      logic clr_step;
      logic scan_init;
      logic scan_step;
      logic found;
      logic mark_init;
      logic mark_step;
      logic set_fail;
      logic set_done;
   } cmd_type;

   typedef struct packed {
      logic is_alloc;
      logic zero_count;
      logic hint_out;
      logic clr_done;
      logic scan_found;
      logic scan_last;
      logic mark_empty;
      logic mark_last;
   } status_type;

endpackage
`default_nettype wire

// ===== sv/bbalc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Request and response channel interfaces of the bitmap block allocator.
// Depends on bbalc_pkg for field widths.
interface bbalc_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          op;
   logic [bbalc_pkg::ADDR_BITS-1:0]     address;
   logic [bbalc_pkg::COUNT_BITS-1:0]    block_count;
   logic [bbalc_pkg::LEN_BITS-1:0]      byte_length;
   modport source (output valid, op, address, block_count, byte_length, input ready);
   modport sink (input valid, op, address, block_count, byte_length, output ready);
endinterface

interface bbalc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                ok;
   logic [bbalc_pkg::ADDR_BITS-1:0]     alloc_address;
   modport source (output valid, ok, alloc_address, input ready);
   modport sink (input valid, ok, alloc_address, output ready);
endinterface
`default_nettype wire

// ===== sv/bbalc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Controller state machine of the bitmap block allocator.
// Depends on bbalc_pkg for the command and status structs.
module bbalc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire bbalc_pkg::status_type status,
   output bbalc_pkg::cmd_type        cmd
);

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_OFF     = 4'd2;
   localparam logic [3:0] S_FIRST   = 4'd3;
   localparam logic [3:0] S_END     = 4'd4;
   localparam logic [3:0] S_CHK     = 4'd5;
   localparam logic [3:0] S_SCAN_RD = 4'd6;
   localparam logic [3:0] S_SCAN    = 4'd7;
   localparam logic [3:0] S_FOUND   = 4'd8;
   localparam logic [3:0] S_MARK_RD = 4'd9;
   localparam logic [3:0] S_MARK    = 4'd10;
   localparam logic [3:0] S_RESP    = 4'd11;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_OFF;
            end
         end
         S_OFF: begin
            cmd.calc_off = 1'b1;
            if (status.is_alloc) begin
               if (status.zero_count || status.hint_out) begin
                  cmd.set_fail = 1'b1;
                  state_in     = S_RESP;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end else begin
               state_in = S_FIRST;
            end
         end
         S_FIRST: begin
            cmd.calc_first = 1'b1;
            state_in       = S_END;
         end
         S_END: begin
            cmd.calc_end = 1'b1;
            state_in     = S_CHK;
         end
         S_CHK: begin
            if (status.mark_empty) begin
               cmd.set_done = 1'b1;
               state_in     = S_RESP;
            end else begin
               state_in = S_MARK_RD;
            end
         end
         S_SCAN_RD: begin
            cmd.scan_init = 1'b1;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_found) begin
               state_in = S_FOUND;
            end else if (status.scan_last) begin
               cmd.set_fail = 1'b1;
               state_in     = S_RESP;
            end
         end
         S_FOUND: begin
            cmd.found = 1'b1;
            state_in  = S_MARK_RD;
         end
         S_MARK_RD: begin
            cmd.mark_init = 1'b1;
            state_in      = S_MARK;
         end
         S_MARK: begin
            cmd.mark_step = 1'b1;
            if (status.mark_last) begin
               cmd.set_done = !status.is_alloc;
               state_in     = S_RESP;
            end
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/bbalc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Datapath of the bitmap block allocator: registers, bitmap memory, scan and mark logic.
// Depends on bbalc_pkg; driven by bbalc_ctrl through the command struct.
module bbalc_dp #(
   parameter int NUM_BLOCKS  = bbalc_pkg::NUM_BLOCKS_DEFAULT,
   parameter int BLOCK_BYTES = bbalc_pkg::BLOCK_BYTES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic                              csr_index,
   input  wire logic [bbalc_pkg::ADDR_BITS-1:0]   csr_data,
   input  wire logic [1:0]                        in_op,
   input  wire logic [bbalc_pkg::ADDR_BITS-1:0]   in_address,
   input  wire logic [bbalc_pkg::COUNT_BITS-1:0]  in_block_count,
   input  wire logic [bbalc_pkg::LEN_BITS-1:0]    in_byte_length,
   input  wire bbalc_pkg::cmd_type                cmd,
   output bbalc_pkg::status_type                  status,
   output logic                                   out_ok,
   output logic [bbalc_pkg::ADDR_BITS-1:0]        out_alloc_address
);

   localparam int WB     = bbalc_pkg::WORD_BITS;
   localparam int LOG_WB = $clog2(WB);
   localparam int LOG_BB = $clog2(BLOCK_BYTES);
   localparam int BW     = $clog2(NUM_BLOCKS) + 1;
   localparam int ROWS   = NUM_BLOCKS / WB;
   localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int FW     = bbalc_pkg::ADDR_BITS + 1;
   localparam int AW     = bbalc_pkg::ADDR_BITS;

   logic [WB-1:0] mem [ROWS];

   logic [AW-1:0]                     base_ff;
   logic [bbalc_pkg::COUNT_BITS-1:0]  managed_ff;
   logic [1:0]                        op_ff;
   logic [AW-1:0]                     addr_ff;
   logic [bbalc_pkg::COUNT_BITS-1:0]  count_ff;
   logic [bbalc_pkg::LEN_BITS-1:0]    len_ff;
   logic [AW-1:0]                     off_ff;
   logic [FW-1:0]                     first_ff;
   logic [FW-1:0]                     n_ff;
   logic [BW-1:0]                     endc_ff;
   logic [BW-1:0]                     hint_ff;
   logic [BW-1:0]                     run_ff;
   logic [BW-1:0]                     start_ff;
   logic [RW-1:0]                     row_ff;
   logic [RW-1:0]                     clr_row_ff;
   logic [WB-1:0]                     rd_data_ff;
   logic                              ok_ff;
   logic [AW-1:0]                     res_ff;

   logic [BW-1:0]  lim;
   logic [BW-1:0]  row_blk;
   logic           is_free;
   logic           is_used;
   logic [FW-1:0]  end_sum;
   logic [BW-1:0]  run_in;
   logic [BW-1:0]  start_in;
   logic           found_in;
   logic [WB-1:0]  mark_word;
   logic           rd_en;
   logic [RW-1:0]  rd_addr;
   logic           wr_en;
   logic [RW-1:0]  wr_addr;
   logic [WB-1:0]  wr_data;

   assign lim = (32'(managed_ff) > NUM_BLOCKS) ? BW'(NUM_BLOCKS) : BW'(managed_ff);
   assign row_blk = BW'({row_ff, {LOG_WB{1'b0}}});
   assign is_free = (op_ff == bbalc_pkg::OP_FREE) || (op_ff == bbalc_pkg::OP_MARK_FREE);
   assign is_used = !is_free;
   assign end_sum = first_ff + n_ff;

   always_comb begin
      logic [BW-1:0] idx;
      run_in   = run_ff;
      start_in = start_ff;
      found_in = 1'b0;
      for (int b = 0; b < WB; b++) begin
         idx = row_blk + BW'(b);
         if (!found_in && idx >= hint_ff && idx < lim) begin
            if (rd_data_ff[b]) begin
               run_in   = '0;
               start_in = idx + BW'(1);
            end else begin
               run_in = run_in + BW'(1);
               if (32'(run_in) >= 32'(count_ff)) found_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      logic [BW-1:0] idx;
      for (int b = 0; b < WB; b++) begin
         idx = row_blk + BW'(b);
         if (FW'(idx) >= first_ff && idx < endc_ff) begin
            mark_word[b] = is_used;
         end else begin
            mark_word[b] = rd_data_ff[b];
         end
      end
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = row_ff + RW'(1);
      wr_en   = 1'b0;
      wr_addr = row_ff;
      wr_data = mark_word;
      if (cmd.scan_init) begin
         rd_en   = 1'b1;
         rd_addr = RW'(hint_ff >> LOG_WB);
      end else if (cmd.mark_init) begin
         rd_en   = 1'b1;
         rd_addr = RW'(first_ff >> LOG_WB);
      end else if (cmd.scan_step) begin
         rd_en = !status.scan_last;
      end else if (cmd.mark_step) begin
         rd_en = !status.mark_last;
         wr_en = 1'b1;
      end else if (cmd.clr_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_row_ff;
         wr_data = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= '0;
         managed_ff <= bbalc_pkg::COUNT_BITS'(4096);
         hint_ff    <= '0;
         clr_row_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == bbalc_pkg::REG_REGION_BASE) begin
               base_ff <= csr_data;
            end else begin
               managed_ff <= csr_data[bbalc_pkg::COUNT_BITS-1:0];
            end
         end
         if (cmd.clr_step) clr_row_ff <= clr_row_ff + RW'(1);
         if (cmd.calc_end && is_free && first_ff < FW'(hint_ff)) begin
            hint_ff <= BW'(first_ff);
         end
         if (cmd.found && count_ff == bbalc_pkg::COUNT_BITS'(1)) begin
            hint_ff <= start_ff + BW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= in_op;
         addr_ff  <= in_address;
         count_ff <= in_block_count;
         len_ff   <= in_byte_length;
      end
      if (cmd.calc_off) off_ff <= addr_ff - base_ff;
      if (cmd.calc_first) begin
         if (is_free) begin
            first_ff <= (FW'(off_ff) + FW'(BLOCK_BYTES - 1)) >> LOG_BB;
         end else begin
            first_ff <= FW'(off_ff) >> LOG_BB;
         end
         case (op_ff)
            bbalc_pkg::OP_FREE:      n_ff <= FW'(count_ff);
            bbalc_pkg::OP_MARK_USED: n_ff <= (FW'(len_ff) + FW'(BLOCK_BYTES - 1)) >> LOG_BB;
            default:                 n_ff <= FW'(len_ff) >> LOG_BB;
         endcase
      end
      if (cmd.calc_end) begin
         endc_ff <= (end_sum > FW'(lim)) ? lim : BW'(end_sum);
      end
      if (cmd.scan_init) begin
         row_ff   <= RW'(hint_ff >> LOG_WB);
         run_ff   <= '0;
         start_ff <= hint_ff;
      end
      if (cmd.scan_step) begin
         row_ff   <= row_ff + RW'(1);
         run_ff   <= run_in;
         start_ff <= start_in;
      end
      if (cmd.found) begin
         first_ff <= FW'(start_ff);
         endc_ff  <= start_ff + BW'(count_ff);
         ok_ff    <= 1'b1;
         res_ff   <= base_ff + (AW'(start_ff) << LOG_BB);
      end
      if (cmd.mark_init) row_ff <= RW'(first_ff >> LOG_WB);
      if (cmd.mark_step) row_ff <= row_ff + RW'(1);
      if (cmd.set_fail) begin
         ok_ff  <= 1'b0;
         res_ff <= '0;
      end
      if (cmd.set_done) begin
         ok_ff  <= 1'b1;
         res_ff <= '0;
      end
   end

   always_comb begin
      status.is_alloc   = (op_ff == bbalc_pkg::OP_ALLOC);
      status.zero_count = (count_ff == '0);
      status.hint_out   = (hint_ff >= lim);
      status.clr_done   = (32'(clr_row_ff) == ROWS - 1);
      status.scan_found = found_in;
      status.scan_last  = (32'(row_blk) + WB >= 32'(lim));
      status.mark_empty = (first_ff >= FW'(endc_ff));
      status.mark_last  = (32'(row_blk) + WB >= 32'(endc_ff));
   end

   assign out_ok            = ok_ff;
   assign out_alloc_address = res_ff;

endmodule
`default_nettype wire

// ===== sv/bitmap_block_allocator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Bitmap block allocator, one request at a time. After reset a clearing pass over all
// NUM_BLOCKS/8 words zeroes the bitmap before the first request is taken. The bitmap
// is kept in 8-bit words of a memory read one word per cycle: an allocation scans the
// words from the hint until a free run is found or the managed blocks end, then marks it,
// and a free or mark request computes its first block and end before marking its run.
// The result is held in an output register until the response transfer completes.
module bitmap_block_allocator_top #(
   parameter int NUM_BLOCKS  = bbalc_pkg::NUM_BLOCKS_DEFAULT,
   parameter int BLOCK_BYTES = bbalc_pkg::BLOCK_BYTES_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic                            csr_index,
   input  wire logic [bbalc_pkg::ADDR_BITS-1:0] csr_data,
   bbalc_req_if.sink                            req_bus,
   bbalc_rsp_if.source                          rsp_bus
);

   bbalc_pkg::cmd_type    cmd;
   bbalc_pkg::status_type status;

   bbalc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bbalc_dp #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .in_op             (req_bus.op),
      .in_address        (req_bus.address),
      .in_block_count    (req_bus.block_count),
      .in_byte_length    (req_bus.byte_length),
      .cmd               (cmd),
      .status            (status),
      .out_ok            (rsp_bus.ok),
      .out_alloc_address (rsp_bus.alloc_address)
   );

endmodule
`default_nettype wire

// ===== sv/bbalc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for the bitmap block allocator and its bind to the top level.
// Depends on bbalc_pkg for widths.
module bbalc_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic                            rsp_ok,
   input wire logic [bbalc_pkg::ADDR_BITS-1:0] rsp_alloc_address
);

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("Request accepted during the clearing pass.");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready && !rsp_valid)
      else $error("Request or response overlapped an accepted transfer.");

   a_fail_zero_address: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_alloc_address == '0))
      else $error("Failed allocation returned a nonzero address.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_alloc_address))
      else $error("Response changed while stalled.");

endmodule

bind bitmap_block_allocator_top bbalc_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_ok            (rsp_bus.ok),
   .rsp_alloc_address (rsp_bus.alloc_address)
);
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_block_allocator_top: random and directed requests,
// an internal bitmap predictor and a checker for every response transfer.
// Depends on bbalc_pkg, the bbalc_req_if/bbalc_rsp_if interfaces and the allocator RTL.
module testbench;

   localparam int NBLK  = bbalc_pkg::NUM_BLOCKS_DEFAULT;
   localparam int BSIZE = bbalc_pkg::BLOCK_BYTES_DEFAULT;
   localparam longint unsigned CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [1:0]                       op;
      logic [bbalc_pkg::ADDR_BITS-1:0]  address;
      logic [bbalc_pkg::COUNT_BITS-1:0] block_count;
      logic [bbalc_pkg::LEN_BITS-1:0]   byte_length;
   } request_type;

   typedef struct {
      logic                            ok;
      logic [bbalc_pkg::ADDR_BITS-1:0] alloc_address;
   } response_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_index;
   logic [bbalc_pkg::ADDR_BITS-1:0] csr_data;

   bbalc_req_if req_bus();
   bbalc_rsp_if rsp_bus();

   bitmap_block_allocator_top dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   request_type  pending_requests[$];
   response_type expected_responses[$];

   bit              block_used[NBLK];
   longint unsigned search_start;
   logic [bbalc_pkg::ADDR_BITS-1:0]  base_shadow;
   logic [bbalc_pkg::COUNT_BITS-1:0] managed_shadow;

   int  failures = 0;
   longint unsigned cycle_count = 0;
   bit  req_busy = 0;
   int  req_gap = 0;
   int  rsp_stall = 0;
   bit  gaps_enabled = 1;

   function automatic longint unsigned live_blocks();
      return (managed_shadow < NBLK) ? longint'(managed_shadow) : NBLK;
   endfunction

   function automatic void set_blocks(longint unsigned first, longint unsigned count, bit used);
      longint unsigned stop;
      stop = first + count;
      if (!used && first < search_start) search_start = first;
      if (stop > live_blocks()) stop = live_blocks();
      for (longint unsigned i = first; i < stop; i++) block_used[i] = used;
   endfunction

   function automatic longint unsigned block_offset(logic [bbalc_pkg::ADDR_BITS-1:0] addr);
      logic [bbalc_pkg::ADDR_BITS-1:0] diff;
      diff = addr - base_shadow;
      return longint'(diff);
   endfunction

   function automatic response_type allocate_response(request_type r);
      response_type res;
      longint unsigned run_start, run_len, count, first;
      logic [63:0] byte_addr;
      res.ok = 1'b1;
      res.alloc_address = '0;
      count = r.block_count;
      case (r.op)
         bbalc_pkg::OP_ALLOC: begin
            res.ok = 1'b0;
            if (count != 0) begin
               run_start = search_start;
               run_len = 0;
               for (longint unsigned i = search_start; i < live_blocks(); i++) begin
                  if (block_used[i]) begin
                     run_len = 0;
                     run_start = i + 1;
                  end else begin
                     if (count == 1) search_start = run_start + 1;
                     run_len++;
                     if (run_len >= count) begin
                        res.ok = 1'b1;
                        break;
                     end
                  end
               end
               if (res.ok) begin
                  set_blocks(run_start, count, 1'b1);
                  byte_addr = 64'(base_shadow) + run_start * BSIZE;
                  res.alloc_address = byte_addr[bbalc_pkg::ADDR_BITS-1:0];
               end
            end
         end
         bbalc_pkg::OP_FREE: begin
            first = (block_offset(r.address) + BSIZE - 1) / BSIZE;
            set_blocks(first, count, 1'b0);
         end
         bbalc_pkg::OP_MARK_USED: begin
            first = block_offset(r.address) / BSIZE;
            set_blocks(first, (longint'(r.byte_length) + BSIZE - 1) / BSIZE, 1'b1);
         end
         default: begin
            first = (block_offset(r.address) + BSIZE - 1) / BSIZE;
            set_blocks(first, longint'(r.byte_length) / BSIZE, 1'b0);
         end
      endcase
      return res;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("bitmap_block_allocator_top verification failed");
         $finish;
      end
   end

   // Request side: the model is advanced at each accepted transfer.
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         expected_responses.push_back(allocate_response(pending_requests[0]));
         void'(pending_requests.pop_front());
         req_busy = 0;
         req_gap = gaps_enabled ? $urandom_range(0, 19) : 0;
      end
   end

   always @(negedge clock) begin
      if (!req_busy) begin
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_bus.op          <= pending_requests[0].op;
            req_bus.address     <= pending_requests[0].address;
            req_bus.block_count <= pending_requests[0].block_count;
            req_bus.byte_length <= pending_requests[0].byte_length;
            req_bus.valid       <= 1'b1;
            req_busy = 1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response side.
   always @(posedge clock) begin
      response_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_responses.size() == 0) begin
            $error("unexpected response transfer: ok=%0b alloc_address=%h",
                   rsp_bus.ok, rsp_bus.alloc_address);
            failures++;
         end else begin
            want = expected_responses.pop_front();
            if (rsp_bus.ok !== want.ok) begin
               $error("ok: expected %0b, actual %0b", want.ok, rsp_bus.ok);
               failures++;
            end
            if (rsp_bus.alloc_address !== want.alloc_address) begin
               $error("alloc_address: expected %h, actual %h",
                      want.alloc_address, rsp_bus.alloc_address);
               failures++;
            end
         end
         rsp_stall = gaps_enabled ? $urandom_range(0, 19) : 0;
      end
   end

   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic push_request(logic [1:0] op, logic [bbalc_pkg::ADDR_BITS-1:0] addr,
                               logic [bbalc_pkg::COUNT_BITS-1:0] count,
                               logic [bbalc_pkg::LEN_BITS-1:0] len);
      request_type r;
      r.op = op;
      r.address = addr;
      r.block_count = count;
      r.byte_length = len;
      pending_requests.push_back(r);
   endtask

   task automatic drain();
      wait (pending_requests.size() == 0 && expected_responses.size() == 0 && !req_busy);
      repeat (5) @(negedge clock);
   endtask

   task automatic write_register(logic index, logic [bbalc_pkg::ADDR_BITS-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      if (index == bbalc_pkg::REG_REGION_BASE) base_shadow = value;
      else managed_shadow = value[bbalc_pkg::COUNT_BITS-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_requests(int n);
      int pick;
      longint unsigned span;
      logic [1:0] op;
      logic [bbalc_pkg::ADDR_BITS-1:0] addr;
      logic [bbalc_pkg::COUNT_BITS-1:0] count;
      logic [bbalc_pkg::LEN_BITS-1:0] len;
      span = live_blocks();
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         op = (pick < 45) ? bbalc_pkg::OP_ALLOC : (pick < 65) ? bbalc_pkg::OP_FREE :
              (pick < 82) ? bbalc_pkg::OP_MARK_USED : bbalc_pkg::OP_MARK_FREE;
         pick = $urandom_range(0, 99);
         if (pick < 85) count = bbalc_pkg::COUNT_BITS'($urandom_range(1, 8));
         else if (pick < 96) count = bbalc_pkg::COUNT_BITS'($urandom_range(0, span + 2));
         else count = bbalc_pkg::COUNT_BITS'($urandom);
         if ($urandom_range(0, 9) != 0)
            addr = base_shadow + bbalc_pkg::ADDR_BITS'($urandom_range(0, span)) * BSIZE
                   + $urandom_range(0, BSIZE - 1);
         else
            addr = bbalc_pkg::ADDR_BITS'({$urandom, $urandom});
         pick = $urandom_range(0, 99);
         if (pick < 94) len = $urandom_range(0, 12 * BSIZE);
         else len = $urandom;
         push_request(op, addr, count, len);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = bbalc_pkg::REG_REGION_BASE;
      csr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.op = bbalc_pkg::OP_ALLOC;
      req_bus.address = '0;
      req_bus.block_count = '0;
      req_bus.byte_length = '0;
      rsp_bus.ready = 1'b0;
      base_shadow = '0;
      managed_shadow = 13'd4096;
      search_start = 0;
      foreach (block_used[i]) block_used[i] = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed checks at the reset configuration.
      push_request(bbalc_pkg::OP_ALLOC, '0, 13'd0, '0);
      push_request(bbalc_pkg::OP_ALLOC, '0, 13'd1, '0);
      push_request(bbalc_pkg::OP_ALLOC, '0, 13'd4096, '0);
      push_request(bbalc_pkg::OP_ALLOC, '0, 13'h1FFF, '0);
      push_request(bbalc_pkg::OP_FREE, '0, 13'd1, '0);
      push_request(bbalc_pkg::OP_MARK_USED, 48'd4101, '0, 32'd1);
      push_request(bbalc_pkg::OP_MARK_USED, 48'd8192, '0, 32'd0);
      push_request(bbalc_pkg::OP_MARK_FREE, 48'd1, '0, 32'd8192);
      push_request(bbalc_pkg::OP_MARK_FREE, '0, '0, 32'hFFFF_FFFF);
      push_request(bbalc_pkg::OP_ALLOC, '0, 13'd4096, '0);
      push_request(bbalc_pkg::OP_ALLOC, '0, 13'd1, '0);
      push_request(bbalc_pkg::OP_FREE, 48'hFFFF_FFFF_FFFF, 13'd4, '0);
      push_request(bbalc_pkg::OP_FREE, '0, 13'h1FFF, '0);
      push_request(bbalc_pkg::OP_MARK_USED, 48'hFFFF_FFFF_FFFF, '0, 32'hFFFF_FFFF);
      push_request(bbalc_pkg::OP_ALLOC, '0, 13'd3, '0);
      push_request(bbalc_pkg::OP_ALLOC, '0, 13'd1, '0);
      push_request(bbalc_pkg::OP_MARK_FREE, 48'd8192, '0, 32'd4096);
      push_request(bbalc_pkg::OP_ALLOC, '0, 13'd1, '0);
      push_request(bbalc_pkg::OP_MARK_USED, 48'd40000, '0, 32'd20000);
      push_request(bbalc_pkg::OP_ALLOC, '0, 13'd5, '0);
      random_requests(120);
      drain();

      // One managed block, base at the top of the address space.
      write_register(bbalc_pkg::REG_REGION_BASE, 48'hFFFF_FFFF_F000);
      write_register(bbalc_pkg::REG_MANAGED_BLOCKS, 48'd1);
      push_request(bbalc_pkg::OP_ALLOC, '0, 13'd1, '0);
      push_request(bbalc_pkg::OP_ALLOC, '0, 13'd1, '0);
      push_request(bbalc_pkg::OP_FREE, 48'hFFFF_FFFF_F000, 13'd1, '0);
      push_request(bbalc_pkg::OP_ALLOC, '0, 13'd2, '0);
      push_request(bbalc_pkg::OP_MARK_USED, 48'hFFFF_FFFF_EFFF, '0, 32'd4096);
      push_request(bbalc_pkg::OP_ALLOC, '0, 13'd1, '0);
      random_requests(40);
      drain();

      // No managed blocks at all.
      write_register(bbalc_pkg::REG_MANAGED_BLOCKS, 48'd0);
      push_request(bbalc_pkg::OP_ALLOC, '0, 13'd1, '0);
      push_request(bbalc_pkg::OP_FREE, '0, 13'd3, '0);
      drain();

      gaps_enabled = 0;
      write_register(bbalc_pkg::REG_REGION_BASE, bbalc_pkg::ADDR_BITS'({$urandom, $urandom}));
      write_register(bbalc_pkg::REG_MANAGED_BLOCKS, 48'd100);
      random_requests(80);
      drain();

      gaps_enabled = 1;
      write_register(bbalc_pkg::REG_REGION_BASE, 48'h0000_1234_5000);
      write_register(bbalc_pkg::REG_MANAGED_BLOCKS, 48'd4096);
      random_requests(140);
      drain();

      write_register(bbalc_pkg::REG_MANAGED_BLOCKS, 48'h1FFF);
      write_register(bbalc_pkg::REG_REGION_BASE, bbalc_pkg::ADDR_BITS'({$urandom, $urandom}));
      random_requests(120);
      drain();

      repeat (50) @(posedge clock);
      if (failures == 0) begin
         $display("bitmap_block_allocator_top verification clean");
      end else begin
         $display("bitmap_block_allocator_top verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/bbalc_pkg.sv
sv/bbalc_if.sv
sv/bbalc_ctrl.sv
sv/bbalc_dp.sv
sv/bitmap_block_allocator_top.sv
sv/bbalc_checker.sv
sim/testbench.sv
